/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define MHPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// antecedent implies consequent in the same cycle
`define MHPQ_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* rtl/core/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared types and constants of the max priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int CAPACITY        = 128;
   localparam int VALUE_WIDTH     = 32;
   localparam int IN_WIDTH        = 32;
   localparam int COUNT_OUT_WIDTH = 8;
   localparam int CNT_W           = $clog2(CAPACITY + 1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [CNT_W-1:0]              count_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   // operation broadcast to every cell of the row
   typedef struct packed {
      logic      ins_en;
      logic      rem_en;
      value_type value;
   } cell_op_type;

   // keep the low bits of the input beat, sign-extended to the stored width
   function automatic value_type fit_value(input logic signed [IN_WIDTH-1:0] v);
      return VALUE_WIDTH'(v);
   endfunction

endpackage

/* rtl/core/mhpq_cell.sv */
// ----------------------------------------------------------------------------
// mhpq_cell
// one slot of the sorted entry row, largest entry at the head
// ----------------------------------------------------------------------------
module mhpq_cell import mhpq_pkg::*; (
   input  logic        clock,
   input  cell_op_type op,
   input  logic        occupied,
   input  logic        prev_place,
   input  value_type   prev_data,
   input  value_type   next_data,
   output logic        place,
   output value_type   data
);

   value_type data_ff;
   value_type data_in;

   // new value belongs at or ahead of this slot
   assign place = !occupied || (op.value > data_ff);

   always_comb begin
      data_in = data_ff;
      if (op.ins_en) begin
         if (prev_place) begin
            data_in = prev_data;
         end else if (place) begin
            data_in = op.value;
         end
      end else if (op.rem_en) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* rtl/core/mhpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mhpq_ctrl
// command capture, entry count and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mhpq_ctrl import mhpq_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_cmd,
   input  logic signed [IN_WIDTH-1:0]        req_value,
   input  value_type                         head_data,
   output cell_op_type                       cell_op,
   output count_type                         count,
   output logic                              rsp_strobe,
   output logic signed [IN_WIDTH-1:0]        rsp_max_value,
   output logic                              rsp_removed_valid,
   output logic                              rsp_underflow,
   output logic                              rsp_overflow,
   output logic [COUNT_OUT_WIDTH-1:0]        rsp_entry_count
);

   logic       accept;
   logic       busy_ff, busy_in;
   cmd_type    cmd_ff;
   value_type  value_ff;
   count_type  count_ff, count_in;
   logic       full, empty, ins_ok, rem_ok, under, over;

   logic                              rsp_strobe_ff;
   logic signed [IN_WIDTH-1:0]        rsp_max_value_ff;
   logic                              rsp_removed_valid_ff;
   logic                              rsp_underflow_ff;
   logic                              rsp_overflow_ff;
   logic [COUNT_OUT_WIDTH-1:0]        rsp_entry_count_ff;

   assign accept  = start && !busy_ff;
   assign busy_in = accept;

   assign full   = (count_ff == count_type'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign ins_ok = busy_ff && (cmd_ff == CMD_INSERT) && !full;
   assign rem_ok = busy_ff && (cmd_ff == CMD_REMOVE) && !empty;
   assign under  = busy_ff && (cmd_ff == CMD_REMOVE) && empty;
   assign over   = busy_ff && (cmd_ff == CMD_INSERT) && full;

   always_comb begin
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + 1'b1;
      end else if (rem_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign cell_op.ins_en = ins_ok;
   assign cell_op.rem_en = rem_ok;
   assign cell_op.value  = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd_type'(req_cmd);
         value_ff <= fit_value(req_value);
      end
      rsp_max_value_ff     <= rem_ok ? IN_WIDTH'(head_data) : '0;
      rsp_removed_valid_ff <= rem_ok;
      rsp_underflow_ff     <= under;
      rsp_overflow_ff      <= over;
      rsp_entry_count_ff   <= COUNT_OUT_WIDTH'(count_in);
   end

   assign busy              = busy_ff;
   assign count             = count_ff;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_max_value     = rsp_max_value_ff;
   assign rsp_removed_valid = rsp_removed_valid_ff;
   assign rsp_underflow     = rsp_underflow_ff;
   assign rsp_overflow      = rsp_overflow_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;

   `MHPQ_ASSERT(a_count_range, count_ff <= count_type'(CAPACITY), "entry count above capacity")
   `MHPQ_ASSERT(a_busy_then_rsp, busy_ff |=> rsp_strobe_ff, "busy cycle not followed by result")
   `MHPQ_ASSERT_IMPLY(a_one_flag, rsp_strobe_ff, !(rsp_removed_valid_ff && rsp_underflow_ff) && !(rsp_removed_valid_ff && rsp_overflow_ff) && !(rsp_underflow_ff && rsp_overflow_ff), "more than one result flag")
   `MHPQ_ASSERT_IMPLY(a_remove_dec, rsp_strobe_ff && rsp_removed_valid_ff, count_ff == count_type'($past(count_ff) - 1'b1), "remove did not drop the count")

endmodule

/* rtl/core/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// max priority queue of signed entries held in a sorted row of cells
// ----------------------------------------------------------------------------
// the result strobe follows the accepting edge through the busy register, then the strobe register
// busy is high for the cycle after accept, and no new command is accepted while busy is high
// during the busy cycle the registered op drives the cell row's update
// reset clears the entry count, busy and the strobe; cell contents are not cleared
// results cannot be stalled: each one is shown for exactly one cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module max_heap_priority_queue import mhpq_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_cmd,
   input  logic signed [IN_WIDTH-1:0]        req_value,
   // result channel
   output logic                              rsp_strobe,
   output logic signed [IN_WIDTH-1:0]        rsp_max_value,
   output logic                              rsp_removed_valid,
   output logic                              rsp_underflow,
   output logic                              rsp_overflow,
   output logic [COUNT_OUT_WIDTH-1:0]        rsp_entry_count
);

   // op broadcast to the row, valid only during the busy cycle
   cell_op_type          cell_op;
   count_type            count;

   // row state: slot 0 holds the maximum, entries kept in descending order
   value_type            cell_data [CAPACITY];
   logic [CAPACITY-1:0]  cell_place;
   logic [CAPACITY-1:0]  occupied;

   mhpq_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .head_data         (cell_data[0]),
      .cell_op           (cell_op),
      .count             (count),
      .rsp_strobe        (rsp_strobe),
      .rsp_max_value     (rsp_max_value),
      .rsp_removed_valid (rsp_removed_valid),
      .rsp_underflow     (rsp_underflow),
      .rsp_overflow      (rsp_overflow),
      .rsp_entry_count   (rsp_entry_count)
   );

   // insert: the slot where the new value lands takes it, slots behind it take
   // their head-side neighbor; remove: each slot but the last takes its tail-side neighbor
   for (genvar g = 0; g < CAPACITY; g++) begin : g_row
      logic      prev_place;
      value_type prev_data;
      value_type next_data;

      // slot holds a live entry
      assign occupied[g] = (count > CNT_W'(g));

      if (g == 0) begin : g_head
         assign prev_place = 1'b0;
         assign prev_data  = '0;
      end else begin : g_body
         assign prev_place = cell_place[g-1];
         assign prev_data  = cell_data[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         // last slot has no neighbor; what it keeps is past the count
         assign next_data = cell_data[g];
      end else begin : g_inner
         assign next_data = cell_data[g+1];
      end

      mhpq_cell u_cell (
         .clock      (clock),
         .op         (cell_op),
         .occupied   (occupied[g]),
         .prev_place (prev_place),
         .prev_data  (prev_data),
         .next_data  (next_data),
         .place      (cell_place[g]),
         .data       (cell_data[g])
      );
   end

   // live entries stay in descending order
   for (genvar g = 0; g < CAPACITY - 1; g++) begin : g_order_chk
      `MHPQ_ASSERT_IMPLY(a_sorted, occupied[g+1], cell_data[g] >= cell_data[g+1], "row out of order")
   end

endmodule

/* tb/max_heap_priority_queue_tb.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// drives insert and remove-max commands into the priority queue and checks
// every result beat against a max-heap predictor kept in the testbench
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb import mhpq_pkg::*; ();

   // result beat as the predictor builds it, one field per result port
   typedef struct packed {
      logic signed [IN_WIDTH-1:0]   max_value;
      logic                         removed_valid;
      logic                         underflow;
      logic                         overflow;
      logic [COUNT_OUT_WIDTH-1:0]   entry_count;
   } heap_result_type;

   // value classes for stimulus
   localparam int VAL_ANY     = 0;
   localparam int VAL_NARROW  = 1;
   localparam int VAL_EXTREME = 2;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic                              req_cmd;
   logic signed [IN_WIDTH-1:0]        req_value;
   logic                              rsp_strobe;
   logic signed [IN_WIDTH-1:0]        rsp_max_value;
   logic                              rsp_removed_valid;
   logic                              rsp_underflow;
   logic                              rsp_overflow;
   logic [COUNT_OUT_WIDTH-1:0]        rsp_entry_count;

   // predictor state: one-based heap and its entry count
   value_type     model_heap [1:CAPACITY];
   int unsigned   model_count;

   heap_result_type  pending_heap_results[$];
   int            error_count;
   int            removed_total;
   int            underflow_total;
   int            overflow_total;
   int            beats_sent;
   bit            burst_mode;

   max_heap_priority_queue uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_max_value     (rsp_max_value),
      .rsp_removed_valid (rsp_removed_valid),
      .rsp_underflow     (rsp_underflow),
      .rsp_overflow      (rsp_overflow),
      .rsp_entry_count   (rsp_entry_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor: applies one command to the model heap, returns the result
   // ------------------------------------------------------------------------
   function automatic heap_result_type predict_heap_op(cmd_type op,
                                                       logic signed [IN_WIDTH-1:0] din);
      heap_result_type  r;
      int unsigned   pos;
      int unsigned   kid;
      int unsigned   best;
      value_type     tmp;
      r = '0;
      if (op == CMD_INSERT) begin
         if (model_count >= CAPACITY) begin
            // full: nothing stored
            r.overflow = 1'b1;
         end else begin
            model_count++;
            model_heap[model_count] = fit_value(din);
            pos = model_count;
            // sift up while the parent is strictly smaller
            while (pos > 1 && model_heap[pos / 2] < model_heap[pos]) begin
               tmp = model_heap[pos / 2];
               model_heap[pos / 2] = model_heap[pos];
               model_heap[pos] = tmp;
               pos = pos / 2;
            end
         end
      end else if (model_count == 0) begin
         r.underflow = 1'b1;
      end else begin
         r.max_value = IN_WIDTH'(model_heap[1]);
         r.removed_valid = 1'b1;
         model_heap[1] = model_heap[model_count];
         model_count--;
         pos = 1;
         // sift down toward the larger child, left one wins a tie
         while (1) begin
            best = pos;
            kid = 2 * pos;
            if (kid <= model_count && model_heap[kid] > model_heap[best]) best = kid;
            if (kid + 1 <= model_count && model_heap[kid + 1] > model_heap[best])
               best = kid + 1;
            if (best == pos) break;
            tmp = model_heap[pos];
            model_heap[pos] = model_heap[best];
            model_heap[best] = tmp;
            pos = best;
         end
      end
      r.entry_count = COUNT_OUT_WIDTH'(model_count);
      return r;
   endfunction

   function automatic logic signed [IN_WIDTH-1:0] pick_value(int kind);
      int sel;
      sel = $urandom_range(0, 5);
      if (kind == VAL_NARROW) return $urandom_range(0, 8) - 4;
      if (kind == VAL_EXTREME) begin
         case (sel)
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return 32'sh7fff_fffe;
         endcase
      end
      return $urandom;
   endfunction

   // ------------------------------------------------------------------------
   // one command beat: optional idle gap, then hold start until accepted
   // ------------------------------------------------------------------------
   task automatic issue_heap_cmd(cmd_type op, logic signed [IN_WIDTH-1:0] din);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 12);
      @(negedge clock);
      if (gap > 0) begin
         // idle: start low, payload ports carry noise
         start     <= 1'b0;
         req_cmd   <= 1'($urandom_range(0, 1));
         req_value <= $urandom;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_cmd   <= op;
      req_value <= din;
      // busy sampled at the edge, before the block updates it
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_heap_results.push_back(predict_heap_op(op, din));
      beats_sent++;
   endtask

   task automatic report_error(string what);
      error_count++;
      if (error_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // ------------------------------------------------------------------------
   // result checker: every strobe is matched to the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      heap_result_type want;
      if (!reset && rsp_strobe) begin
         if (rsp_removed_valid) removed_total++;
         if (rsp_underflow) underflow_total++;
         if (rsp_overflow) overflow_total++;
         if (pending_heap_results.size() == 0) begin
            report_error($sformatf("result beat with nothing pending, max_value %0d",
                                   rsp_max_value));
         end else begin
            want = pending_heap_results.pop_front();
            if (rsp_max_value !== want.max_value)
               report_error($sformatf("max_value: expected %0d, got %0d",
                                      want.max_value, rsp_max_value));
            if (rsp_removed_valid !== want.removed_valid)
               report_error($sformatf("removed_valid: expected %0b, got %0b",
                                      want.removed_valid, rsp_removed_valid));
            if (rsp_underflow !== want.underflow)
               report_error($sformatf("underflow: expected %0b, got %0b",
                                      want.underflow, rsp_underflow));
            if (rsp_overflow !== want.overflow)
               report_error($sformatf("overflow: expected %0b, got %0b",
                                      want.overflow, rsp_overflow));
            if (rsp_entry_count !== want.entry_count)
               report_error($sformatf("entry_count: expected %0d, got %0d",
                                      want.entry_count, rsp_entry_count));
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // remove on the empty queue right after reset
   task automatic test_remove_empty;
      burst_mode = 1'b0;
      issue_heap_cmd(CMD_REMOVE, 32'sh1234_5678);
   endtask

   // extremes of the value range and alternating bit patterns come out in order,
   // then one more remove underflows
   task automatic test_extreme_values;
      burst_mode = 1'b1;
      issue_heap_cmd(CMD_INSERT, 32'sh8000_0000);
      issue_heap_cmd(CMD_INSERT, 32'sh7fff_ffff);
      issue_heap_cmd(CMD_INSERT, 0);
      issue_heap_cmd(CMD_INSERT, -1);
      issue_heap_cmd(CMD_INSERT, 32'sh5555_5555);
      issue_heap_cmd(CMD_INSERT, 32'shaaaa_aaaa);
      repeat (7) issue_heap_cmd(CMD_REMOVE, $urandom);
   endtask

   // duplicates force ties between equal children during sift-down
   task automatic test_equal_values;
      burst_mode = 1'b0;
      issue_heap_cmd(CMD_INSERT, 7);
      issue_heap_cmd(CMD_INSERT, 7);
      issue_heap_cmd(CMD_INSERT, 2);
      issue_heap_cmd(CMD_INSERT, 7);
      issue_heap_cmd(CMD_INSERT, 7);
      repeat (5) issue_heap_cmd(CMD_REMOVE, 0);
   endtask

   // fill to capacity with random content, overflow, refill the freed slot,
   // then drain completely and underflow
   task automatic test_fill_and_drain;
      burst_mode = $urandom_range(0, 1);
      while (model_count < CAPACITY)
         issue_heap_cmd(CMD_INSERT, pick_value($urandom_range(VAL_ANY, VAL_EXTREME)));
      repeat (3) issue_heap_cmd(CMD_INSERT, pick_value(VAL_ANY));
      issue_heap_cmd(CMD_REMOVE, $urandom);
      issue_heap_cmd(CMD_INSERT, pick_value(VAL_NARROW));
      issue_heap_cmd(CMD_INSERT, 32'sh7fff_ffff);
      burst_mode = $urandom_range(0, 1);
      while (model_count > 0) issue_heap_cmd(CMD_REMOVE, $urandom);
      repeat (2) issue_heap_cmd(CMD_REMOVE, $urandom);
   endtask

   // random mix in segments, each with its own insert bias, value class and
   // idling, so the heap wanders between empty, mid-size and nearly full
   task automatic test_random_mix(int segments);
      int pct;
      int kind;
      repeat (segments) begin
         case ($urandom_range(0, 3))
            0: pct = 30;
            1: pct = 50;
            2: pct = 70;
            default: pct = 90;
         endcase
         kind = $urandom_range(VAL_ANY, VAL_EXTREME);
         burst_mode = ($urandom_range(0, 3) == 0);
         repeat (30) begin
            if ($urandom_range(0, 99) < pct)
               issue_heap_cmd(CMD_INSERT, pick_value(kind));
            else
               issue_heap_cmd(CMD_REMOVE, $urandom);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int waited;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_INSERT;
      req_value = '0;
      model_count = 0;
      error_count = 0;
      removed_total = 0;
      underflow_total = 0;
      overflow_total = 0;
      beats_sent = 0;
      burst_mode = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_remove_empty();
      test_extreme_values();
      test_equal_values();
      test_fill_and_drain();
      test_random_mix(11);

      @(negedge clock);
      start <= 1'b0;
      // drain outstanding results, then keep watching for stray strobes
      waited = 0;
      while (pending_heap_results.size() != 0 && waited < 50) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_heap_results.size() != 0)
         report_error($sformatf("%0d results never arrived", pending_heap_results.size()));

      $display("covered %0d command beats: %0d maxima removed, %0d underflows, %0d overflows",
               beats_sent, removed_total, underflow_total, overflow_total);
      $display("mismatches counted: %0d", error_count);
      if (error_count == 0)
         $display("max_heap_priority_queue_tb: PASS");
      else
         $display("max_heap_priority_queue_tb: FAIL");
      $finish;
   end

   // watchdog, well above the slowest legal run
   initial begin
      #5000000;
      $display("timeout waiting on the block");
      $display("max_heap_priority_queue_tb: FAIL");
      $finish;
   end

endmodule
